// File: rtl/core/tsf_pkg.sv
// ----------------------------------------------------------------------------
// tsf_pkg: shared types and constants of the triangular smoothing filter
// Sample and register widths, the chain control bundle and the tap weight.
// ----------------------------------------------------------------------------
package tsf_pkg;

   localparam int SAMPLE_W     = 16;
   localparam int TAPS_W       = 6;
   localparam int SEEN_W       = 6;
   localparam int MAX_TAPS_DEF = 32;

   localparam logic [SEEN_W-1:0]   SEEN_MAX   = '1;
   localparam logic [TAPS_W-1:0]   TAPS_RESET = TAPS_W'(1);
   localparam logic [SAMPLE_W-1:0] SMP_POS    = 16'h7FFF;
   localparam logic [SAMPLE_W-1:0] SMP_NEG    = 16'h8000;

   // control from the sequencer to every cell of the chain
   typedef struct packed {
      logic shift;   // move samples one cell toward the old end
      logic clear;   // zero all samples (end of waveform)
      logic calc;    // advance the partial-sum ripple
   } chain_ctl_type;

   // Weight seen by the cell at position idx (0 = newest) for n taps, h = n/2.
   // Position idx corresponds to tap m = 2h - idx; weight is min(m+1, n-m).
   function automatic int tap_weight(int n, int h, int idx);
      int a;
      int b;
      a = 2 * h - idx + 1;
      b = n - 2 * h + idx;
      if (a < 1 || b < 1) begin
         return 0;
      end
      return (a < b) ? a : b;
   endfunction

endpackage

// File: rtl/core/tsf_cell.sv
// ----------------------------------------------------------------------------
// tsf_cell: one stage of the sample chain
// Holds one delayed sample, weights it by its tap position and adds the
// product to the partial sum coming from its newer neighbor.
// ----------------------------------------------------------------------------
module tsf_cell
   import tsf_pkg::*;
#(
   parameter int IDX   = 0,
   parameter int NT_W  = 6,
   parameter int H_W   = 5,
   parameter int W_W   = 5,
   parameter int ACC_W = 25
) (
   input  logic                       clock,
   input  logic                       reset,
   input  chain_ctl_type              ctl,
   input  logic [NT_W-1:0]            num_eff,
   input  logic [H_W-1:0]             half,
   input  logic signed [SAMPLE_W-1:0] sample_in,
   input  logic signed [ACC_W-1:0]    psum_in,
   output logic signed [SAMPLE_W-1:0] sample_out,
   output logic signed [ACC_W-1:0]    psum_out
);

   logic signed [SAMPLE_W-1:0]  sample_ff, sample_next_in;
   logic signed [ACC_W-1:0]     psum_ff, psum_next_in;
   logic [W_W-1:0]              weight;
   logic signed [SAMPLE_W+W_W:0] product;

   assign weight  = W_W'(tap_weight(int'(num_eff), int'(half), IDX));
   assign product = sample_ff * $signed({1'b0, weight});

   always_comb begin
      sample_next_in = sample_ff;
      priority if (ctl.clear) begin
         sample_next_in = '0;
      end else if (ctl.shift) begin
         sample_next_in = sample_in;
      end
   end

   assign psum_next_in = psum_in + ACC_W'(product);

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else begin
         sample_ff <= sample_next_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.calc) begin
         psum_ff <= psum_next_in;
      end
   end

   assign sample_out = sample_ff;
   assign psum_out   = psum_ff;

endmodule

// File: rtl/core/tsf_div.sv
// ----------------------------------------------------------------------------
// tsf_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tsf_div
   import tsf_pkg::*;
#(
   parameter int NUM_W = 27,
   parameter int DEN_W = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic             fits;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = numer;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = fits ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         den_ff <= denom;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/core/triangular_smoothing_filter_core.sv
// ----------------------------------------------------------------------------
// triangular_smoothing_filter_core: centered triangular FIR smoother
// Sample chain of weighting cells, ripple partial sum, rounding divider.
// ----------------------------------------------------------------------------
// One item at a time. With five taps or fewer a sample passes straight
// through. Otherwise each result lets the partial sum ripple down the chain of
// MAX_TAPS+1 cells, then runs the bit-serial divider and its done flag (NUM_W is
// 16 + clog2((MAX_TAPS/2+1)^2+1) + 2, i.e. 27 at 32 taps). A sample may yield
// no result; the last sample of a waveform yields h further results,
// h = min(num_taps, MAX_TAPS)/2. Output lags input by h samples and the chain
// clears after each last beat. A finished result waits in the output register
// until taken.
// ----------------------------------------------------------------------------
module triangular_smoothing_filter_core
   import tsf_pkg::*;
#(
   parameter int MAX_TAPS = MAX_TAPS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write,
   input  logic [TAPS_W-1:0]          csr_num_taps,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_last_in,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_smoothed,
   output logic                       rsp_last_out
);

   localparam int NT_W  = $clog2(MAX_TAPS + 1);
   localparam int H_W   = $clog2(MAX_TAPS / 2 + 1);
   localparam int W_W   = $clog2(MAX_TAPS / 2 + 2);
   localparam int WS_W  = $clog2((MAX_TAPS / 2 + 1) * (MAX_TAPS / 2 + 1) + 1);
   localparam int ACC_W = SAMPLE_W + WS_W;
   localparam int NUM_W = ACC_W + 2;
   localparam int DEN_W = WS_W + 1;
   localparam int CNT_W = $clog2(MAX_TAPS + 2);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CHECK  = 3'd1;
   localparam logic [2:0] ST_CALC   = 3'd2;
   localparam logic [2:0] ST_DSTART = 3'd3;
   localparam logic [2:0] ST_DWAIT  = 3'd4;
   localparam logic [2:0] ST_EMIT   = 3'd5;

   logic [2:0]                 state_ff, state_in;
   logic [TAPS_W-1:0]          taps_ff;
   logic [H_W-1:0]             e_ff, e_in;
   logic [SEEN_W-1:0]          seen_ff, seen_in;
   logic [CNT_W-1:0]           calc_cnt_ff, calc_cnt_in;
   logic signed [SAMPLE_W-1:0] cur_ff;
   logic                       last_ff;
   logic                       neg_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_smoothed_ff;
   logic                       rsp_last_out_ff;

   logic [NT_W-1:0]            num_eff;
   logic [H_W-1:0]             half;
   logic [H_W-1:0]             top;
   logic                       bypass;
   logic [WS_W-1:0]            wsum;
   logic                       accept;
   logic                       load;
   logic                       div_start;
   logic                       div_done;
   logic [NUM_W-1:0]           div_quo;
   logic [NUM_W-1:0]           quo_neg;
   logic [ACC_W-1:0]           mag;
   logic [NUM_W-1:0]           numer;
   logic signed [SAMPLE_W-1:0] rounded;
   logic signed [SAMPLE_W-1:0] result;
   logic                       finish;
   chain_ctl_type              ctl;
   logic signed [SAMPLE_W-1:0] chain_src;
   logic signed [SAMPLE_W-1:0] sample_q [0:MAX_TAPS];
   logic signed [ACC_W-1:0]    psum_q   [0:MAX_TAPS];
   logic signed [ACC_W-1:0]    acc;

   assign num_eff = (int'(taps_ff) > MAX_TAPS) ? NT_W'(MAX_TAPS) : NT_W'(taps_ff);
   assign half    = H_W'(num_eff >> 1);
   assign bypass  = half <= H_W'(2);
   assign top     = (last_ff && !bypass) ? half : '0;
   // even N: h(h+1), odd N: (h+1)^2
   assign wsum    = WS_W'((int'(half) + 1) * (int'(half) + int'(num_eff[0])));

   assign accept = req_valid && !req_stall;
   assign load   = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in    = state_ff;
      e_in        = e_ff;
      calc_cnt_in = calc_cnt_ff;
      ctl         = '0;
      chain_src   = '0;
      div_start   = 1'b0;
      finish      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ctl.shift = 1'b1;
               chain_src = req_sample;
               e_in      = '0;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            priority if (bypass) begin
               state_in = ST_EMIT;
            end else if (int'(seen_ff) + int'(e_ff) >= int'(half)) begin
               calc_cnt_in = '0;
               state_in    = ST_CALC;
            end else if (e_ff < top) begin
               ctl.shift = 1'b1;
               e_in      = e_ff + H_W'(1);
            end else begin
               finish   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_CALC: begin
            ctl.calc    = 1'b1;
            calc_cnt_in = calc_cnt_ff + CNT_W'(1);
            if (calc_cnt_ff == CNT_W'(MAX_TAPS)) begin
               state_in = ST_DSTART;
            end
         end
         ST_DSTART: begin
            div_start = 1'b1;
            state_in  = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (load) begin
               if (e_ff < top) begin
                  // flush: feed a zero past the end of the waveform
                  ctl.shift = 1'b1;
                  e_in      = e_ff + H_W'(1);
                  state_in  = ST_CHECK;
               end else begin
                  finish   = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (finish && last_ff) begin
         ctl.clear = 1'b1;
      end
   end

   always_comb begin
      seen_in = seen_ff;
      if (finish) begin
         if (last_ff) begin
            seen_in = '0;
         end else if (seen_ff != SEEN_MAX) begin
            seen_in = seen_ff + SEEN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         taps_ff     <= TAPS_RESET;
         seen_ff     <= '0;
         e_ff        <= '0;
         calc_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         seen_ff     <= seen_in;
         e_ff        <= e_in;
         calc_cnt_ff <= calc_cnt_in;
         if (csr_write) begin
            taps_ff <= csr_num_taps;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cur_ff  <= req_sample;
         last_ff <= req_last_in;
      end
      if (div_start) begin
         neg_ff <= acc[ACC_W-1];
      end
   end

   // ---------------------------------------------------------------- cell chain
   for (genvar j = 0; j <= MAX_TAPS; j++) begin : g_cell
      tsf_cell #(
         .IDX   (j),
         .NT_W  (NT_W),
         .H_W   (H_W),
         .W_W   (W_W),
         .ACC_W (ACC_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .num_eff    (num_eff),
         .half       (half),
         .sample_in  ((j == 0) ? chain_src : sample_q[(j == 0) ? 0 : j - 1]),
         .psum_in    ((j == 0) ? '0 : psum_q[(j == 0) ? 0 : j - 1]),
         .sample_out (sample_q[j]),
         .psum_out   (psum_q[j])
      );
   end

   assign acc = psum_q[MAX_TAPS];

   // ---------------------------------------------------------------- rounding
   // q = (2|s| + w) / 2w rounds to nearest, ties away from zero
   assign mag   = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
   assign numer = NUM_W'({mag, 1'b0}) + NUM_W'(wsum);

   tsf_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (numer),
      .denom    ({wsum, 1'b0}),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign quo_neg = -div_quo;

   always_comb begin
      if (!neg_ff) begin
         rounded = (div_quo > NUM_W'(SMP_POS)) ? SMP_POS : div_quo[SAMPLE_W-1:0];
      end else begin
         rounded = (div_quo > NUM_W'(SMP_NEG)) ? SMP_NEG : quo_neg[SAMPLE_W-1:0];
      end
   end

   assign result = bypass ? cur_ff : rounded;

   // ---------------------------------------------------------------- output
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_smoothed_ff <= result;
         rsp_last_out_ff <= last_ff && (e_ff == top);
      end
   end

   assign req_stall    = state_ff != ST_IDLE;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_smoothed = rsp_smoothed_ff;
   assign rsp_last_out = rsp_last_out_ff;

endmodule

// File: rtl/core/tsf_checker.sv
// ----------------------------------------------------------------------------
// tsf_checker: port-level checks of the triangular smoothing filter
// Watches the top level's ports only; attached by bind.
// ----------------------------------------------------------------------------
module tsf_checker
   import tsf_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       csr_write,
   input logic [TAPS_W-1:0]          csr_num_taps,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic signed [SAMPLE_W-1:0] req_sample,
   input logic                       req_last_in,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic signed [SAMPLE_W-1:0] rsp_smoothed,
   input logic                       rsp_last_out
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_smoothed) && $stable(rsp_last_out))
      else $error("result beat changed while stalled");

   // a stalled input beat holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=>
         req_valid && $stable(req_sample) && $stable(req_last_in))
      else $error("input beat changed while stalled");

   // one item in flight: an accepted beat closes the input
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted while an item is in flight");

   // tap count only changes while the block is empty
   a_cfg_idle: assert property (@(posedge clock) disable iff (reset)
      csr_write |-> !req_stall && !rsp_valid && !$isunknown(csr_num_taps))
      else $error("tap count written while busy");

   // reset leaves the block empty and ready
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind triangular_smoothing_filter_core tsf_checker u_tsf_checker (.*);
